FILE: hw/rtl/ptfr_pkg.sv
// ----------------------------------------------------------------------------
// ptfr_pkg
// Shared constants and types for the paged address translation block with
// FIFO replacement.
// ----------------------------------------------------------------------------
package ptfr_pkg;

    // Page size is fixed here. It must be a power of two so that the page
    // number and the offset are plain bit fields of the logical address.
    localparam int unsigned PAGE_SIZE_DEF   = 256;
    // Default page and frame counts; the top level hands these down as
    // parameters.
    localparam int unsigned PAGE_COUNT_DEF  = 8;
    localparam int unsigned FRAME_COUNT_DEF = 4;

    // Fixed field widths of the ports.
    localparam int unsigned ADDR_W         = 16;
    localparam int unsigned PHYS_ADDR_W    = 10;
    localparam int unsigned FRAME_USED_W   = 2;
    localparam int unsigned EVICTED_PAGE_W = 3;
    localparam int unsigned COUNT_W        = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // Latch the incoming address.
        logic commit;   // Update the tables and load the result register.
    } ptfr_cmd_t;

endpackage

FILE: hw/rtl/ptfr_ctrl.sv
// ----------------------------------------------------------------------------
// ptfr_ctrl
// Controller: sequences capture and commit of one beat and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module ptfr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output ptfr_pkg::ptfr_cmd_t cmd
);
    import ptfr_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free   = !out_valid_reg || !out_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.commit  = (state_reg == S_EXEC) && slot_free;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A beat is never captured in the same cycle as a commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit overlap");

    // A commit always presents a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise out_valid");

    // An accepted beat moves the controller into execution.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("capture did not start execution");

endmodule

FILE: hw/rtl/ptfr_datapath.sv
// ----------------------------------------------------------------------------
// ptfr_datapath
// Datapath: page table, frame owner table, fill count, victim pointer,
// saturating counters and the result register.
// ----------------------------------------------------------------------------
module ptfr_datapath
#(
    parameter int unsigned PAGE_COUNT  = ptfr_pkg::PAGE_COUNT_DEF,
    parameter int unsigned FRAME_COUNT = ptfr_pkg::FRAME_COUNT_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ptfr_pkg::ptfr_cmd_t                    cmd,
    input  logic [ptfr_pkg::ADDR_W-1:0]            logical_address,
    output logic                                   address_invalid,
    output logic [ptfr_pkg::PHYS_ADDR_W-1:0]       physical_address,
    output logic                                   was_hit,
    output logic [ptfr_pkg::FRAME_USED_W-1:0]      frame_used,
    output logic                                   evicted,
    output logic [ptfr_pkg::EVICTED_PAGE_W-1:0]    evicted_page,
    output logic [ptfr_pkg::COUNT_W-1:0]           hits_so_far,
    output logic [ptfr_pkg::COUNT_W-1:0]           faults_so_far
);
    import ptfr_pkg::*;

    localparam int unsigned OFFSET_W   = $clog2(PAGE_SIZE_DEF);
    localparam int unsigned PN_W       = ADDR_W - OFFSET_W;
    localparam int unsigned PAGE_IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int unsigned FRAME_W    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int unsigned FILL_W     = $clog2(FRAME_COUNT + 1);
    localparam int unsigned PHYS_W     = FRAME_W + OFFSET_W;

    logic [ADDR_W-1:0]     addr_reg;
    logic [PAGE_COUNT-1:0] page_valid_reg;
    logic [PAGE_COUNT-1:0] page_valid_next;
    logic [FRAME_W-1:0]    page_frame_reg [PAGE_COUNT];
    logic [FRAME_COUNT-1:0] frame_valid_reg;
    logic [PAGE_IDX_W-1:0] frame_owner_reg [FRAME_COUNT];
    logic [FILL_W-1:0]     frames_filled_reg;
    logic [FRAME_W-1:0]    victim_ptr_reg;
    logic [COUNT_W-1:0]    hit_total_reg;
    logic [COUNT_W-1:0]    fault_total_reg;

    logic                      invalid_reg;
    logic [PHYS_ADDR_W-1:0]    phys_reg;
    logic                      hit_reg;
    logic [FRAME_USED_W-1:0]   frame_used_reg;
    logic                      evicted_reg;
    logic [EVICTED_PAGE_W-1:0] evicted_page_reg;
    logic [COUNT_W-1:0]        hits_out_reg;
    logic [COUNT_W-1:0]        faults_out_reg;

    logic [PN_W-1:0]       page_num;
    logic [OFFSET_W-1:0]   offset;
    logic [PAGE_IDX_W-1:0] page_idx;
    logic                  invalid;
    logic                  hit;
    logic                  fill;
    logic                  evict;
    logic [FRAME_W-1:0]    frame;
    logic [PAGE_IDX_W-1:0] old_page;
    logic [FRAME_W-1:0]    victim_ptr_next;
    logic [PHYS_W-1:0]     phys_full;
    logic [COUNT_W-1:0]    hit_total_next;
    logic [COUNT_W-1:0]    fault_total_next;
    logic                  do_update;
    logic                  do_miss;

    always_comb
    begin
        page_num  = addr_reg[ADDR_W-1:OFFSET_W];
        offset    = addr_reg[OFFSET_W-1:0];
        page_idx  = PAGE_IDX_W'(page_num);
        invalid   = (32'(page_num) >= 32'(PAGE_COUNT));
        hit       = page_valid_reg[page_idx];
        fill      = (32'(frames_filled_reg) < 32'(FRAME_COUNT));
        old_page  = frame_owner_reg[victim_ptr_reg];
        evict     = !hit && !fill && frame_valid_reg[victim_ptr_reg];
        if (hit)
        begin
            frame = page_frame_reg[page_idx];
        end
        else if (fill)
        begin
            frame = FRAME_W'(frames_filled_reg);
        end
        else
        begin
            frame = victim_ptr_reg;
        end
        if (32'(victim_ptr_reg) == 32'(FRAME_COUNT - 1))
        begin
            victim_ptr_next = '0;
        end
        else
        begin
            victim_ptr_next = victim_ptr_reg + FRAME_W'(1);
        end
        // The faulting page was not resident, so it never equals the victim.
        page_valid_next = page_valid_reg;
        if (evict)
        begin
            page_valid_next[old_page] = 1'b0;
        end
        page_valid_next[page_idx] = 1'b1;
        phys_full        = {frame, offset};
        hit_total_next   = (hit_total_reg == '1) ? hit_total_reg
                                                 : hit_total_reg + COUNT_W'(1);
        fault_total_next = (fault_total_reg == '1) ? fault_total_reg
                                                   : fault_total_reg + COUNT_W'(1);
        do_update        = cmd.commit && !invalid;
        do_miss          = do_update && !hit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= logical_address;
        end
        if (do_miss)
        begin
            frame_owner_reg[frame] <= page_idx;
            page_frame_reg[page_idx] <= frame;
        end
        if (cmd.commit)
        begin
            invalid_reg <= invalid;
            if (invalid)
            begin
                phys_reg         <= '0;
                hit_reg          <= 1'b0;
                frame_used_reg   <= '0;
                evicted_reg      <= 1'b0;
                evicted_page_reg <= '0;
                hits_out_reg     <= hit_total_reg;
                faults_out_reg   <= fault_total_reg;
            end
            else
            begin
                phys_reg         <= PHYS_ADDR_W'(phys_full);
                hit_reg          <= hit;
                frame_used_reg   <= FRAME_USED_W'(frame);
                evicted_reg      <= evict;
                evicted_page_reg <= evict ? EVICTED_PAGE_W'(old_page) : '0;
                hits_out_reg     <= hit ? hit_total_next : hit_total_reg;
                faults_out_reg   <= hit ? fault_total_reg : fault_total_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_valid_reg    <= '0;
            frame_valid_reg   <= '0;
            frames_filled_reg <= '0;
            victim_ptr_reg    <= '0;
            hit_total_reg     <= '0;
            fault_total_reg   <= '0;
        end
        else if (do_update)
        begin
            if (hit)
            begin
                hit_total_reg <= hit_total_next;
            end
            else
            begin
                fault_total_reg <= fault_total_next;
                if (fill)
                begin
                    frames_filled_reg <= frames_filled_reg + FILL_W'(1);
                end
                else
                begin
                    victim_ptr_reg <= victim_ptr_next;
                end
                page_valid_reg         <= page_valid_next;
                frame_valid_reg[frame] <= 1'b1;
            end
        end
    end

    assign address_invalid  = invalid_reg;
    assign physical_address = phys_reg;
    assign was_hit          = hit_reg;
    assign frame_used       = frame_used_reg;
    assign evicted          = evicted_reg;
    assign evicted_page     = evicted_page_reg;
    assign hits_so_far      = hits_out_reg;
    assign faults_so_far    = faults_out_reg;

    // The fill count never passes the number of frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(frames_filled_reg) <= 32'(FRAME_COUNT))
        else $error("frame fill count overflow");

    // The victim pointer only moves once every frame has been handed out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (victim_ptr_reg != '0) |-> (32'(frames_filled_reg) == 32'(FRAME_COUNT)))
        else $error("victim pointer moved before frames filled");

    // The victim pointer always names an existing frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(victim_ptr_reg) < 32'(FRAME_COUNT))
        else $error("victim pointer out of range");

    // An eviction in the result always comes with a fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !(evicted_reg && hit_reg))
        else $error("eviction reported on a hit");

endmodule

FILE: hw/rtl/page_translate_fifo_replace.sv
// ----------------------------------------------------------------------------
// page_translate_fifo_replace
// Paged logical-to-physical address translation with FIFO frame replacement
// and saturating hit and fault counters.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  -------------------------------------------
//  input     in_valid / in_stall  logical_address
//  output    out_valid/out_stall  address_invalid, physical_address, was_hit,
//                                 frame_used, evicted, evicted_page,
//                                 hits_so_far, faults_so_far
//
//  Each beat is first captured, then committed: the commit looks up the
//  page table, updates the tables and loads the result register.
//  The next beat is taken in the cycle after the commit at the earliest;
//  in_stall holds off new beats until the current beat has committed.
//  The result register holds its beat while out_stall is high; a new beat
//  can be captured meanwhile and waits in execution until the slot frees.
//  Reset clears the page and frame valid bits, the fill count, the victim
//  pointer and both counters at once; there is no clearing pass.
//
module page_translate_fifo_replace
#(
    parameter int unsigned PAGE_COUNT  = ptfr_pkg::PAGE_COUNT_DEF,
    parameter int unsigned FRAME_COUNT = ptfr_pkg::FRAME_COUNT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ptfr_pkg::ADDR_W-1:0]         logical_address,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                address_invalid,
    output logic [ptfr_pkg::PHYS_ADDR_W-1:0]    physical_address,
    output logic                                was_hit,
    output logic [ptfr_pkg::FRAME_USED_W-1:0]   frame_used,
    output logic                                evicted,
    output logic [ptfr_pkg::EVICTED_PAGE_W-1:0] evicted_page,
    output logic [ptfr_pkg::COUNT_W-1:0]        hits_so_far,
    output logic [ptfr_pkg::COUNT_W-1:0]        faults_so_far
);
    import ptfr_pkg::*;

    // Capture and commit commands from the controller to the datapath.
    ptfr_cmd_t cmd;

    // The controller sequences each beat and owns out_valid.
    ptfr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath holds the translation tables, counters and result.
    ptfr_datapath
    #(
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .logical_address  (logical_address),
        .address_invalid  (address_invalid),
        .physical_address (physical_address),
        .was_hit          (was_hit),
        .frame_used       (frame_used),
        .evicted          (evicted),
        .evicted_page     (evicted_page),
        .hits_so_far      (hits_so_far),
        .faults_so_far    (faults_so_far)
    );

endmodule
